// File: design/rpfb_pkg.sv
// Package for the rotated page framebuffer: opcodes, register indexes,
// controller states and stream item layouts.
// No dependencies; the top level and the checker refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rpfb_pkg;

  // Stream payload widths
  localparam int IN_W   = 64;
  localparam int USER_W = 3;
  localparam int OUT_W  = 16;

  // Width of a logical point while walking a rectangle (origin + offset, signed)
  localparam int PT_W = 11;

  typedef enum logic [2:0] {
    OP_PIXEL = 3'd0,
    OP_RECT  = 3'd1,
    OP_CLEAR = 3'd2,
    OP_READ  = 3'd3,
    OP_SPAN  = 3'd4
  } op_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_SHIFT_X = 2'd0;
  localparam logic [1:0] CFG_SHIFT_Y = 2'd1;
  localparam logic [1:0] CFG_TURN    = 2'd2;

  typedef enum logic [1:0] {
    TURN_0   = 2'd0,
    TURN_90  = 2'd1,
    TURN_180 = 2'd2,
    TURN_270 = 2'd3
  } turn_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POINT,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_SPAN_MAP,
    ST_SPAN_ACC,
    ST_EMIT
  } state_e;

  // Input transaction, last field in the lowest bits
  typedef struct packed {
    logic [6:0]        column_sel;
    logic [3:0]        page_sel;
    logic              pixel_on;
    logic [7:0]        rect_height;
    logic [7:0]        rect_width;
    logic signed [8:0] corner_y;
    logic signed [8:0] corner_x;
    logic signed [8:0] pos_y;
    logic signed [8:0] pos_x;
  } in_item_t;

  // Result transaction, last field in the lowest bits
  typedef struct packed {
    logic [3:0] last_page;
    logic [3:0] first_page;
    logic [7:0] read_byte;
  } out_item_t;

endpackage

`default_nettype wire

// File: design/rpfb_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Read data holds its value while no read is issued. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rpfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/rotated_page_framebuffer.sv
// Pixel write: accept, map, read, write back for each transaction.
// Rectangle fill: accept, skip each off-panel pixel, map/read/write each on-panel one.
// Clear: one store byte per cycle over all PAGES*SIDE bytes (2048 at SIDE=128).
// Byte read: emit, then result register; area span: map+accumulate per corner, then emit.
// One item in flight at a time: input is ready only while the controller is idle.
// Reset: async, active low; then a clearing pass over all PAGES*SIDE bytes, input stalled.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the rotated page framebuffer.
// Depends on rpfb_pkg and rpfb_ram.
module rotated_page_framebuffer #(
  parameter int SIDE = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [6:0]  cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata, low to high: pos_x[8:0], pos_y[17:9], corner_x[26:18], corner_y[35:27],
  // rect_width[43:36], rect_height[51:44], pixel_on[52], page_sel[56:53],
  // column_sel[63:57]
  input  wire logic [rpfb_pkg::IN_W-1:0]   s_axis_tdata,
  // tuser: op[2:0]
  input  wire logic [rpfb_pkg::USER_W-1:0] s_axis_tuser,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata, low to high: read_byte[7:0], first_page[11:8], last_page[15:12]
  output logic [rpfb_pkg::OUT_W-1:0]       m_axis_tdata
);

  // ------------------------------------------------------------------
  // Geometry. The store is PAGES rows of SIDE bytes; byte (page, col)
  // sits at page*SIDE + col, bit n of it is panel row page*8 + n.
  // ------------------------------------------------------------------
  localparam int CW    = $clog2(SIDE);
  localparam int PAGES = (SIDE + 7) / 8;
  localparam int DEPTH = PAGES * SIDE;
  localparam int AW    = $clog2(DEPTH);
  // Multiple of SIDE that lifts the most negative shifted point to zero or above
  localparam int OFS   = SIDE * ((256 + SIDE - 1) / SIDE);
  localparam int PT_W  = rpfb_pkg::PT_W;

  // Reduce a shifted coordinate into [0, SIDE). The biased value stays
  // below SIDE*128, so seven conditional subtracts of SIDE<<k finish it.
  function automatic logic [CW-1:0] wrap_side(input logic signed [PT_W:0] v);
    logic [15:0] u;
    begin
      u = 16'(v) + 16'(OFS);
      for (int k = 6; k >= 0; k--) begin
        if (u >= (16'(SIDE) << k)) begin
          u = u - (16'(SIDE) << k);
        end
      end
      return CW'(u);
    end
  endfunction

  rpfb_pkg::in_item_t  s_item;
  rpfb_pkg::op_e       s_op;
  logic                in_fire;

  assign s_item  = rpfb_pkg::in_item_t'(s_axis_tdata);
  assign s_op    = rpfb_pkg::op_e'(s_axis_tuser);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  rpfb_pkg::state_e state_q, state_d;
  logic [6:0]       shift_x_q, shift_x_d;
  logic [6:0]       shift_y_q, shift_y_d;
  rpfb_pkg::turn_e  turn_q, turn_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic             out_valid_q, out_valid_d;

  // transaction payload
  rpfb_pkg::op_e           op_q, op_d;
  logic signed [8:0]       pos_x_q, pos_x_d;
  logic signed [8:0]       pos_y_q, pos_y_d;
  logic signed [8:0]       corner_x_q, corner_x_d;
  logic signed [8:0]       corner_y_q, corner_y_d;
  logic [7:0]              w_q, w_d;
  logic [7:0]              h_q, h_d;
  logic                    on_q, on_d;
  logic                    byte_ok_q, byte_ok_d;
  // rectangle walk
  logic [7:0]              i_q, i_d;
  logic [7:0]              j_q, j_d;
  logic signed [PT_W-1:0]  cur_x_q, cur_x_d;
  logic signed [PT_W-1:0]  cur_y_q, cur_y_d;
  // mapped point, read-modify-write target, span accumulation
  logic [CW-1:0]           sx_q, sx_d;
  logic [CW-1:0]           sy_q, sy_d;
  logic [AW-1:0]           addr_q, addr_d;
  logic [2:0]              bit_q, bit_d;
  logic [1:0]              k_q, k_d;
  logic [CW-1:0]           lo_q, lo_d;
  logic [CW-1:0]           hi_q, hi_d;
  rpfb_pkg::out_item_t     out_q, out_d;

  // ------------------------------------------------------------------
  // Shift stage: one wrap unit per axis, shared. During area span it takes the
  // corner picked by k (bit 0 selects corner_x, bit 1 selects corner_y),
  // otherwise the current rectangle point.
  // ------------------------------------------------------------------
  logic signed [PT_W-1:0] pt_x, pt_y;
  logic signed [PT_W:0]   sum_x, sum_y;
  logic [CW-1:0]          map_sx, map_sy;

  always_comb begin
    if (state_q == rpfb_pkg::ST_SPAN_MAP) begin
      pt_x = k_q[0] ? PT_W'(corner_x_q) : PT_W'(pos_x_q);
      pt_y = k_q[1] ? PT_W'(corner_y_q) : PT_W'(pos_y_q);
    end else begin
      pt_x = cur_x_q;
      pt_y = cur_y_q;
    end
  end

  assign sum_x  = (PT_W+1)'(pt_x) + (PT_W+1)'(shift_x_q);
  assign sum_y  = (PT_W+1)'(pt_y) + (PT_W+1)'(shift_y_q);
  assign map_sx = wrap_side(sum_x);
  assign map_sy = wrap_side(sum_y);

  // ------------------------------------------------------------------
  // Rotation stage on the registered shifted point, then byte address
  // ------------------------------------------------------------------
  logic [CW-1:0] rot_px, rot_py;
  logic [AW-1:0] rot_addr;

  always_comb begin
    unique case (turn_q)
      rpfb_pkg::TURN_90: begin
        rot_px = CW'(SIDE - 1) - sy_q;
        rot_py = sx_q;
      end
      rpfb_pkg::TURN_180: begin
        rot_px = CW'(SIDE - 1) - sx_q;
        rot_py = CW'(SIDE - 1) - sy_q;
      end
      rpfb_pkg::TURN_270: begin
        rot_px = sy_q;
        rot_py = CW'(SIDE - 1) - sx_q;
      end
      default: begin
        rot_px = sx_q;
        rot_py = sy_q;
      end
    endcase
  end

  assign rot_addr = AW'((AW+1)'(rot_py >> 3) * (AW+1)'(SIDE) + (AW+1)'(rot_px));

  // Byte read address straight from the port; out-of-range reads give zero
  logic          rd_ok;
  logic [AW-1:0] rd_addr;

  assign rd_ok   = (6'(s_item.page_sel) < 6'(PAGES)) && (9'(s_item.column_sel) < 9'(SIDE));
  assign rd_addr = AW'((AW+1)'(s_item.page_sel) * (AW+1)'(SIDE)
                       + (AW+1)'(s_item.column_sel));

  // ------------------------------------------------------------------
  // Rectangle walk, row-major; a pixel write is a 1x1 rectangle
  // ------------------------------------------------------------------
  logic                   col_end, walk_done, pt_in;
  logic [7:0]             nx_i, nx_j;
  logic signed [PT_W-1:0] nx_x, nx_y;

  assign col_end   = (i_q == w_q - 8'd1);
  assign walk_done = col_end && (j_q == h_q - 8'd1);
  assign nx_i      = col_end ? 8'd0 : i_q + 8'd1;
  assign nx_j      = col_end ? j_q + 8'd1 : j_q;
  assign nx_x      = col_end ? PT_W'(pos_x_q) : cur_x_q + PT_W'(1);
  assign nx_y      = col_end ? cur_y_q + PT_W'(1) : cur_y_q;
  assign pt_in     = !cur_x_q[PT_W-1] && !cur_y_q[PT_W-1]
                     && ($unsigned(cur_x_q) < PT_W'(SIDE))
                     && ($unsigned(cur_y_q) < PT_W'(SIDE));

  // Span pages, masked to four bits
  logic [8:0] lo_w, hi_w;
  assign lo_w = 9'(lo_q);
  assign hi_w = 9'(hi_q);

  // ------------------------------------------------------------------
  // RAM port
  // ------------------------------------------------------------------
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [7:0]    bit_mask;

  assign bit_mask = 8'd1 << bit_q;

  rpfb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // ------------------------------------------------------------------
  // Configuration: always ready; by user rule (unchecked), written only while block is idle
  // ------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_comb begin
    shift_x_d = shift_x_q;
    shift_y_d = shift_y_q;
    turn_d    = turn_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        rpfb_pkg::CFG_SHIFT_X: shift_x_d = cfg_data_i;
        rpfb_pkg::CFG_SHIFT_Y: shift_y_d = cfg_data_i;
        rpfb_pkg::CFG_TURN:    turn_d    = rpfb_pkg::turn_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Controller. Read and write-back of one byte never overlap with the
  // next read: a pixel goes map -> read -> write before the next one
  // is mapped, so no forwarding path is needed.
  // ------------------------------------------------------------------
  assign s_axis_tready = (state_q == rpfb_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    op_d        = op_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    corner_x_d  = corner_x_q;
    corner_y_d  = corner_y_q;
    w_d         = w_q;
    h_d         = h_q;
    on_d        = on_q;
    byte_ok_d   = byte_ok_q;
    i_d         = i_q;
    j_d         = j_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    addr_d      = addr_q;
    bit_d       = bit_q;
    k_d         = k_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = addr_q;
    ram_wdata   = 8'd0;

    unique case (state_q)
      rpfb_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        if (clr_q == AW'(DEPTH - 1)) begin
          clr_d   = '0;
          state_d = rpfb_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      rpfb_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_d       = s_op;
          pos_x_d    = s_item.pos_x;
          pos_y_d    = s_item.pos_y;
          corner_x_d = s_item.corner_x;
          corner_y_d = s_item.corner_y;
          on_d       = s_item.pixel_on;
          cur_x_d    = PT_W'(s_item.pos_x);
          cur_y_d    = PT_W'(s_item.pos_y);
          i_d        = 8'd0;
          j_d        = 8'd0;
          k_d        = 2'd0;
          unique case (s_op)
            rpfb_pkg::OP_PIXEL: begin
              w_d     = 8'd1;
              h_d     = 8'd1;
              state_d = rpfb_pkg::ST_POINT;
            end
            rpfb_pkg::OP_RECT: begin
              w_d = s_item.rect_width;
              h_d = s_item.rect_height;
              if (s_item.rect_width != 8'd0 && s_item.rect_height != 8'd0) begin
                state_d = rpfb_pkg::ST_POINT;
              end
            end
            rpfb_pkg::OP_CLEAR: begin
              clr_d   = '0;
              state_d = rpfb_pkg::ST_CLEAR;
            end
            rpfb_pkg::OP_READ: begin
              byte_ok_d = rd_ok;
              ram_re    = rd_ok;
              ram_addr  = rd_addr;
              state_d   = rpfb_pkg::ST_EMIT;
            end
            rpfb_pkg::OP_SPAN: begin
              state_d = rpfb_pkg::ST_SPAN_MAP;
            end
            default: ;  // unused opcodes: dropped
          endcase
        end
      end

      rpfb_pkg::ST_POINT: begin
        if (pt_in) begin
          sx_d    = map_sx;
          sy_d    = map_sy;
          state_d = rpfb_pkg::ST_RMW_RD;
        end else if (walk_done) begin
          state_d = rpfb_pkg::ST_IDLE;
        end else begin
          i_d     = nx_i;
          j_d     = nx_j;
          cur_x_d = nx_x;
          cur_y_d = nx_y;
        end
      end

      rpfb_pkg::ST_RMW_RD: begin
        ram_re   = 1'b1;
        ram_addr = rot_addr;
        addr_d   = rot_addr;
        bit_d    = rot_py[2:0];
        state_d  = rpfb_pkg::ST_RMW_WR;
      end

      rpfb_pkg::ST_RMW_WR: begin
        ram_we    = 1'b1;
        ram_addr  = addr_q;
        ram_wdata = on_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        if (walk_done) begin
          state_d = rpfb_pkg::ST_IDLE;
        end else begin
          i_d     = nx_i;
          j_d     = nx_j;
          cur_x_d = nx_x;
          cur_y_d = nx_y;
          state_d = rpfb_pkg::ST_POINT;
        end
      end

      rpfb_pkg::ST_SPAN_MAP: begin
        sx_d    = map_sx;
        sy_d    = map_sy;
        state_d = rpfb_pkg::ST_SPAN_ACC;
      end

      rpfb_pkg::ST_SPAN_ACC: begin
        if (k_q == 2'd0 || rot_py < lo_q) begin
          lo_d = rot_py;
        end
        if (k_q == 2'd0 || rot_py > hi_q) begin
          hi_d = rot_py;
        end
        k_d     = k_q + 2'd1;
        state_d = (k_q == 2'd3) ? rpfb_pkg::ST_EMIT : rpfb_pkg::ST_SPAN_MAP;
      end

      rpfb_pkg::ST_EMIT: begin
        // wait for the output register to drain; RAM read data holds meanwhile
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          if (op_q == rpfb_pkg::OP_READ) begin
            out_d.read_byte  = byte_ok_q ? ram_rdata : 8'd0;
            out_d.first_page = 4'd0;
            out_d.last_page  = 4'd0;
          end else begin
            out_d.read_byte  = 8'd0;
            out_d.first_page = lo_w[6:3];
            out_d.last_page  = hi_w[6:3];
          end
          state_d = rpfb_pkg::ST_IDLE;
        end
      end

      default: state_d = rpfb_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpfb_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      shift_x_q   <= 7'd0;
      shift_y_q   <= 7'd0;
      turn_q      <= rpfb_pkg::TURN_0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      shift_x_q   <= shift_x_d;
      shift_y_q   <= shift_y_d;
      turn_q      <= turn_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pos_x_q    <= pos_x_d;
    pos_y_q    <= pos_y_d;
    corner_x_q <= corner_x_d;
    corner_y_q <= corner_y_d;
    w_q        <= w_d;
    h_q        <= h_d;
    on_q       <= on_d;
    byte_ok_q  <= byte_ok_d;
    i_q        <= i_d;
    j_q        <= j_d;
    cur_x_q    <= cur_x_d;
    cur_y_q    <= cur_y_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    addr_q     <= addr_d;
    bit_q      <= bit_d;
    k_q        <= k_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    out_q      <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// File: design/rpfb_checker.sv
// Port-level checker for the rotated page framebuffer, bound to the top level.
// Depends on rpfb_pkg and rotated_page_framebuffer.
`timescale 1ns / 1ps
`default_nettype none

module rpfb_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o,
  input wire logic [1:0]                    cfg_addr_i,
  input wire logic [6:0]                    cfg_data_i,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [rpfb_pkg::IN_W-1:0]     s_axis_tdata,
  input wire logic [rpfb_pkg::USER_W-1:0]   s_axis_tuser,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [rpfb_pkg::OUT_W-1:0]    m_axis_tdata
);

  logic in_fire, res_op;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign res_op  = (s_axis_tuser == rpfb_pkg::OP_READ) || (s_axis_tuser == rpfb_pkg::OP_SPAN);

  // Clearing pass follows reset: no transaction taken right after release
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  // A read or span keeps the block busy once it is accepted
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_op) |=> !s_axis_tready)
    else $error("ready right after a result transaction");

  // Drawing and unused opcodes never produce a result
  a_draw_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !res_op && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result produced by a drawing transaction");

  // A result carries either a byte or a page span, never both
  a_fields_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[15:8] == 8'd0))
    else $error("result mixes byte and page fields");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind rotated_page_framebuffer rpfb_checker u_rpfb_checker (.*);

`default_nettype wire
